/* sv/btc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types and constants for the block transposition cipher.
// ----------------------------------------------------------------------------
package btc_pkg;

    // Key holds eight source positions of three bits each.
    localparam int KEY_ENTRIES   = 8;
    localparam int KEY_POS_W     = 3;
    localparam int KEY_W         = KEY_ENTRIES * KEY_POS_W;

    // Default maximum block length.
    localparam int MAX_BLOCK_DEF = 8;

    // Field widths.
    localparam int BYTE_W        = 8;
    localparam int LEN_CFG_W     = 4;
    localparam int CMP_W         = 4;

    // Configuration port.
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    // Pad byte, ASCII 'X'.
    localparam logic [BYTE_W-1:0]    PAD_BYTE      = 8'h58;

    // Reset values of the configuration registers.
    localparam logic [LEN_CFG_W-1:0] BLOCK_LEN_RST = 4'd1;
    localparam logic [KEY_W-1:0]     PERM_KEY_RST  = 24'hFAC688;

    // Register indexes, taken from paddr bit 2.
    typedef enum logic [0:0] {
        REG_BLOCK_LEN = 1'b0,
        REG_PERM_KEY  = 1'b1
    } reg_idx_t;

    // Block sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT
    } btc_state_t;

endpackage : btc_pkg
`default_nettype wire

/* sv/btc_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btc_ifs
// Valid/ready stream interfaces for message bytes in and cipher bytes out.
// ----------------------------------------------------------------------------
interface btc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       msg_last;

    modport source (output valid, output msg_byte, output msg_last, input ready);
    modport sink   (input valid, input msg_byte, input msg_last, output ready);
endinterface : btc_in_if

interface btc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       block_end;
    logic       msg_end;

    modport source (output valid, output out_byte, output block_end, output msg_end,
                    input ready);
    modport sink   (input valid, input out_byte, input block_end, input msg_end,
                    output ready);
endinterface : btc_out_if
`default_nettype wire

/* sv/btc_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btc_store
// Block buffer: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btc_store #(
    parameter int DEPTH = btc_pkg::MAX_BLOCK_DEF,
    parameter int IDX_W = 3
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [IDX_W-1:0]          waddr,
    input  wire logic [btc_pkg::BYTE_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [IDX_W-1:0]          raddr,
    output logic      [btc_pkg::BYTE_W-1:0] rdata
);
    import btc_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : btc_store
`default_nettype wire

/* sv/block_transposition_cipher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// block_transposition_cipher
// Collects message bytes into a block and emits the block in key order.
// ----------------------------------------------------------------------------
// A byte that does not complete a block is taken while idle. The byte that
// completes a block (or carries msg_last) starts the emit sequence: each
// output byte is read from the block buffer and then loaded into the output
// register once the previous byte is taken; the input stays closed until
// the last byte is loaded. Output position i takes buffered byte key[i]; a
// key entry at or beyond the block length, or naming a position not filled
// in a final partial block, yields the pad byte 'X'. block_len is clamped to
// 1..min(MAX_BLOCK, 8). Configuration is written over the APB port at byte
// address 0 (block_len) and 4 (perm_key) and is sampled when a block is
// emitted.
// ----------------------------------------------------------------------------
module block_transposition_cipher #(
    parameter int MAX_BLOCK = btc_pkg::MAX_BLOCK_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    btc_in_if.sink                           in_ch,
    btc_out_if.source                        out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [btc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [btc_pkg::PDATA_W-1:0] pwdata,
    output logic      [btc_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);
    import btc_pkg::*;

    localparam int DEPTH = (MAX_BLOCK < KEY_ENTRIES) ? MAX_BLOCK : KEY_ENTRIES;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Configuration registers.
    logic [LEN_CFG_W-1:0] block_len_reg;
    logic [KEY_W-1:0]     perm_key_reg;

    // Sequencer state.
    btc_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic                 last_reg, last_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic                 pad_reg, pad_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 blk_end_reg, blk_end_next;
    logic                 msg_end_reg, msg_end_next;

    // Datapath signals.
    logic                 cfg_wr;
    logic [CNT_W-1:0]     eff_len;
    logic [CNT_W-1:0]     held_now;
    logic                 accept;
    logic                 in_ready;
    logic [KEY_POS_W-1:0] src;
    logic                 pad_now;
    logic                 pos_last;
    logic                 mem_re;
    logic [BYTE_W-1:0]    mem_rdata;

    // Configuration write and readback.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_len_reg <= BLOCK_LEN_RST;
            perm_key_reg  <= PERM_KEY_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_BLOCK_LEN: block_len_reg <= pwdata[LEN_CFG_W-1:0];
                REG_PERM_KEY:  perm_key_reg  <= pwdata[KEY_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_BLOCK_LEN: prdata = {{(PDATA_W-LEN_CFG_W){1'b0}}, block_len_reg};
            REG_PERM_KEY:  prdata = {{(PDATA_W-KEY_W){1'b0}}, perm_key_reg};
            default:       prdata = '0;
        endcase
    end

    // Effective block length, clamped to 1..DEPTH.
    always_comb
    begin
        if (block_len_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (block_len_reg > LEN_CFG_W'(DEPTH))
        begin
            eff_len = CNT_W'(DEPTH);
        end
        else
        begin
            eff_len = CNT_W'(block_len_reg);
        end
    end

    // Input handshake and fill level.
    assign in_ready    = (state_reg == ST_IDLE);
    assign in_ch.ready = in_ready;
    assign accept      = in_ch.valid && in_ready;
    assign held_now    = CNT_W'(fill_reg) + CNT_W'(1);

    // Key lookup for the current output position.
    assign src      = perm_key_reg[KEY_POS_W*pos_reg +: KEY_POS_W];
    assign pad_now  = (CMP_W'(src) >= CMP_W'(len_reg)) || (CMP_W'(src) >= CMP_W'(held_reg));
    assign pos_last = ((CNT_W'(pos_reg) + CNT_W'(1)) == len_reg);
    assign mem_re   = (state_reg == ST_READ);

    // Block buffer.
    btc_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (fill_reg),
        .wdata (in_ch.msg_byte),
        .re    (mem_re),
        .raddr (src[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        held_next      = held_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        pad_next       = pad_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_byte_next  = out_byte_reg;
        blk_end_next   = blk_end_reg;
        msg_end_next   = msg_end_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((held_now >= eff_len) || in_ch.msg_last)
                    begin
                        held_next  = held_now;
                        len_next   = eff_len;
                        last_next  = in_ch.msg_last;
                        pos_next   = '0;
                        fill_next  = '0;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        fill_next = held_now[IDX_W-1:0];
                    end
                end
            end
            ST_READ:
            begin
                pad_next   = pad_now;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pad_reg ? PAD_BYTE : mem_rdata;
                    blk_end_next   = pos_last;
                    msg_end_next   = pos_last && last_reg;
                    if (pos_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        held_reg     <= held_next;
        len_reg      <= len_next;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
        pad_reg      <= pad_next;
        out_byte_reg <= out_byte_next;
        blk_end_reg  <= blk_end_next;
        msg_end_reg  <= msg_end_next;
    end

    // Output beat.
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.block_end = blk_end_reg;
    assign out_ch.msg_end   = msg_end_reg;

endmodule : block_transposition_cipher
`default_nettype wire

/* dv/btc_tb_pkg.sv */
// ----------------------------------------------------------------------------
// btc_tb_pkg
// Scoreboard for the block transposition cipher: it mirrors the register
// settings and the block buffer, predicts the cipher bytes of each message
// byte and checks them in order against the bytes that leave the block.
// ----------------------------------------------------------------------------
package btc_tb_pkg;

    import btc_pkg::*;

    // One cipher byte as it appears on the output channel.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              block_end;
        logic              msg_end;
    } cipher_beat_t;

    class cipher_checker;

        int unsigned          max_len;
        logic [LEN_CFG_W-1:0] len_reg;
        logic [KEY_W-1:0]     key_reg;
        logic [BYTE_W-1:0]    block_buf [KEY_ENTRIES];
        logic [KEY_POS_W-1:0] fill;
        cipher_beat_t         expected_beats [$];
        int unsigned          fails;
        int unsigned          plain_beats;
        int unsigned          cipher_beats;
        int unsigned          blocks;
        int unsigned          pad_beats;

        function new(int unsigned max_block);
            max_len      = (max_block < KEY_ENTRIES) ? max_block : KEY_ENTRIES;
            len_reg      = BLOCK_LEN_RST;
            key_reg      = PERM_KEY_RST;
            fill         = '0;
            fails        = 0;
            plain_beats  = 0;
            cipher_beats = 0;
            blocks       = 0;
            pad_beats    = 0;
            foreach (block_buf[i])
                block_buf[i] = '0;
        endfunction

        // Mirror a register write; only the implemented bits are kept.
        function void set_register(reg_idx_t idx, logic [PDATA_W-1:0] value);
            if (idx == REG_BLOCK_LEN)
                len_reg = value[LEN_CFG_W-1:0];
            else
                key_reg = value[KEY_W-1:0];
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction

        // Count a failure; only the first few are described in full.
        function void report(string what);
            fails++;
            if (fails <= 10)
                $display("MISMATCH: %s", what);
        endfunction

        // Take one accepted message byte and queue the block it completes, if any.
        function void take_plain_byte(logic [BYTE_W-1:0] b, logic is_last);
            int unsigned  len;
            int unsigned  held;
            int unsigned  src;
            int unsigned  i;
            cipher_beat_t beat;

            // The length register is clamped to the range the key can serve.
            len = len_reg;
            if (len < 1)
                len = 1;
            if (len > max_len)
                len = max_len;

            plain_beats++;
            block_buf[fill] = b;
            held = int'(fill) + 1;

            // The block is not yet complete and the message goes on.
            if (held < len && !is_last)
            begin
                fill = KEY_POS_W'(held);
                return;
            end

            // Emit the block in key order; keys beyond the length or beyond the
            // bytes held in a short final block give the pad byte.
            for (i = 0; i < len; i++)
            begin
                src = (key_reg >> (KEY_POS_W * i)) & ((1 << KEY_POS_W) - 1);
                if (src < len && src < held)
                begin
                    beat.out_byte = block_buf[src];
                end
                else
                begin
                    beat.out_byte = PAD_BYTE;
                    pad_beats++;
                end
                beat.block_end = (i + 1 == len);
                beat.msg_end   = (i + 1 == len) && is_last;
                expected_beats.insert(expected_beats.size(), beat);
            end
            blocks++;
            fill = '0;
        endfunction

        // Compare one accepted output beat with the oldest prediction.
        function void check_cipher_byte(logic [BYTE_W-1:0] b, logic be, logic me);
            cipher_beat_t want;

            cipher_beats++;
            if (expected_beats.size() == 0)
            begin
                report($sformatf("beat %0d not predicted: byte=%02h block_end=%0b msg_end=%0b",
                                 cipher_beats, b, be, me));
                return;
            end
            want = expected_beats.pop_front();
            if (want.out_byte !== b || want.block_end !== be || want.msg_end !== me)
                report($sformatf({"beat %0d: expected byte=%02h block_end=%0b msg_end=%0b, ",
                                  "got byte=%02h block_end=%0b msg_end=%0b"},
                                 cipher_beats, want.out_byte, want.block_end, want.msg_end,
                                 b, be, me));
        endfunction

    endclass : cipher_checker

endpackage : btc_tb_pkg

/* dv/block_transposition_cipher_tb.sv */
// ----------------------------------------------------------------------------
// block_transposition_cipher_tb
// Self-checking bench for the block transposition cipher. A directed
// sequence covers short final blocks, pad keys, messages ending on a block
// boundary, length and key changes inside a block and out-of-range lengths;
// random phases then run whole messages under many settings, with random
// gaps on both channels, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module block_transposition_cipher_tb;

    import btc_pkg::*;
    import btc_tb_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int IDLE_PCT     = 23;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int LIMIT_CYCLES = 400000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Control shared between the stimulus and the output sink.
    bit                 hold_req = 1'b0;
    bit                 no_idle  = 1'b0;
    int unsigned        reg_writes = 0;

    cipher_checker      sb = new(MAX_BLOCK_DEF);

    btc_in_if  in_ch ();
    btc_out_if out_ch ();

    block_transposition_cipher dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("[block_transposition_cipher] ERROR");
        $finish;
    end

    // Output sink: checks each accepted beat, then picks ready for the next cycle.
    // A hold-off request closes ready while the hold counter runs down.
    initial
    begin
        int unsigned hold_left;

        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_cipher_byte(out_ch.out_byte, out_ch.block_end, out_ch.msg_end);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (no_idle)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offer one message byte, wait for the beat, then idle for a random gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        int unsigned gap;

        in_ch.valid    <= 1'b1;
        in_ch.msg_byte <= b;
        in_ch.msg_last <= is_last;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.take_plain_byte(b, is_last);

        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering, wait for every predicted beat, then let the block go quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] got;
        logic [PDATA_W-1:0] want;

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        sb.set_register(idx, value);
        reg_writes++;

        // Read access to the same address.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        got     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;

        if (idx == REG_BLOCK_LEN)
            want = PDATA_W'(value[LEN_CFG_W-1:0]);
        else
            want = PDATA_W'(value[KEY_W-1:0]);
        if (got !== want)
            sb.report($sformatf("read back of %s: expected %08h, got %08h",
                                idx.name(), want, got));
    endtask

    // One random phase: new settings, then whole messages with random content.
    task automatic random_phase(input logic [LEN_CFG_W-1:0] len, input bit shuffled,
                                input int unsigned n_bytes, input bit stall_sink,
                                input bit drain_mid);
        logic [KEY_W-1:0]     key;
        logic [KEY_POS_W-1:0] perm [KEY_ENTRIES];
        logic [KEY_POS_W-1:0] t;
        int unsigned          j;
        int unsigned          eff;
        int unsigned          sent;
        int unsigned          msg_len;
        int unsigned          k;
        logic                 is_last;

        // Either a true permutation or a raw random key whose entries may repeat.
        if (shuffled)
        begin
            for (j = 0; j < KEY_ENTRIES; j++)
                perm[j] = KEY_POS_W'(j);
            for (j = KEY_ENTRIES - 1; j > 0; j--)
            begin
                k       = $urandom_range(j, 0);
                t       = perm[j];
                perm[j] = perm[k];
                perm[k] = t;
            end
            for (j = 0; j < KEY_ENTRIES; j++)
                key[KEY_POS_W*j +: KEY_POS_W] = perm[j];
        end
        else
        begin
            key = KEY_W'($urandom);
        end
        write_reg(REG_BLOCK_LEN, PDATA_W'(len));
        write_reg(REG_PERM_KEY, PDATA_W'(key));

        eff = (len == 0) ? 1 : (len > KEY_ENTRIES) ? KEY_ENTRIES : len;
        if (stall_sink)
            hold_req = 1'b1;

        // Messages of up to three blocks; now and then one is cut short early.
        sent = 0;
        while (sent < n_bytes)
        begin
            msg_len = $urandom_range(3 * eff, 1);
            for (k = 0; k < msg_len && sent < n_bytes; k++)
            begin
                is_last = (k == msg_len - 1) || ($urandom_range(19) == 0);
                send_byte(BYTE_W'($urandom), is_last);
                sent++;
                if (drain_mid && sent == n_bytes / 2)
                begin
                    in_ch.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (sb.pending() != 0);
                end
                if (is_last)
                    break;
            end
        end
        settle();
    endtask

    // Stimulus.
    initial
    begin
        int unsigned i;
        logic [LEN_CFG_W-1:0] len;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.msg_byte = '0;
        in_ch.msg_last = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings after reset: one-byte blocks, identity key, extreme bytes.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        // Four-byte blocks with one key past the length: a short final block
        // gets pad bytes both for unfilled positions and for that key.
        write_reg(REG_BLOCK_LEN, 4);
        write_reg(REG_PERM_KEY,
                  PDATA_W'({3'd7, 3'd6, 3'd4, 3'd2, 3'd1, 3'd5, 3'd0, 3'd3}));
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h81, 1'b1);

        // Message ending exactly on a block boundary.
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h08, 1'b1);

        // Length lowered and key swapped inside a block: the next byte
        // closes the block and the surplus byte is dropped.
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        settle();
        write_reg(REG_BLOCK_LEN, 2);
        write_reg(REG_PERM_KEY, PDATA_W'(24'hFAC681));
        send_byte(8'h40, 1'b0);
        settle();

        // Zero length behaves as one; the only key entry lies past it.
        write_reg(REG_BLOCK_LEN, 0);
        send_byte(8'h7F, 1'b1);
        settle();

        // Largest register value clamps to eight, identity key, full block.
        write_reg(REG_BLOCK_LEN, 15);
        write_reg(REG_PERM_KEY, PDATA_W'(PERM_KEY_RST));
        for (i = 0; i < 8; i++)
            send_byte(BYTE_W'($urandom), i == 7);
        settle();

        // Random phases: a stretch without gaps, a long output stall,
        // a drain pause, the extreme lengths, then random settings.
        no_idle = 1'b1;
        random_phase(LEN_CFG_W'(8), 1'b1, 30, 1'b0, 1'b0);
        no_idle = 1'b0;
        random_phase(LEN_CFG_W'($urandom_range(8, 1)), 1'b0, 25, 1'b1, 1'b0);
        random_phase(LEN_CFG_W'(15), 1'b1, 25, 1'b0, 1'b1);
        random_phase(LEN_CFG_W'(0), 1'b0, 15, 1'b0, 1'b0);
        random_phase(LEN_CFG_W'(1), 1'b1, 10, 1'b0, 1'b0);
        for (i = 0; i < 5; i++)
        begin
            if ($urandom_range(3) == 0)
                len = LEN_CFG_W'($urandom_range(15, 0));
            else
                len = LEN_CFG_W'($urandom_range(8, 1));
            random_phase(len, 1'($urandom_range(1)), 20, 1'b0, 1'b0);
        end

        $display("Covered %0d message bytes giving %0d cipher bytes in %0d blocks (%0d pad).",
                 sb.plain_beats, sb.cipher_beats, sb.blocks, sb.pad_beats);
        $display("%0d register writes, each read back; %0d failures, %0d beats outstanding.",
                 reg_writes, sb.fails, sb.pending());
        if (sb.fails == 0 && sb.pending() == 0)
            $display("[block_transposition_cipher] OK");
        else
            $display("[block_transposition_cipher] ERROR");
        $finish;
    end

endmodule : block_transposition_cipher_tb
